// ===== sv/tkl_pkg.sv =====
// Shared types and codes for the top-k ranked list.
package tkl_pkg;

  localparam int KeyW   = 64;
  localparam int ScoreW = 32;
  localparam int IdxW   = 3;
  localparam int PosW   = 3;
  localparam int CountW = 4;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  typedef enum logic [1:0] {
    MODE_SEARCH,
    MODE_SHIFT,
    MODE_DONE
  } mode_t;

  // Operation token that walks down the row of cells.
  typedef struct packed {
    logic              valid;
    logic [1:0]        kind;
    mode_t             mode;
    logic [KeyW-1:0]   key;
    logic [ScoreW-1:0] score;
    logic [IdxW-1:0]   idx;
    logic              placed;
    logic [PosW-1:0]   pos;
    logic [KeyW-1:0]   rkey;
    logic [ScoreW-1:0] rscore;
  } token_t;

endpackage

// ===== sv/tkl_cell.sv =====
// One rank slot: holds a (key, score) pair and acts on the passing token.
module tkl_cell import tkl_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  token_t            tok_in,
  output token_t            tok_out,
  output logic [ScoreW-1:0] score_out
);

  logic [KeyW-1:0]   key_q;
  logic [ScoreW-1:0] score_q;
  logic [KeyW-1:0]   key_next;
  logic [ScoreW-1:0] score_next;
  token_t            tok_q;
  token_t            tok_next;

  always_comb begin
    tok_next   = tok_in;
    key_next   = key_q;
    score_next = score_q;
    if (tok_in.valid) begin
      unique case (tok_in.kind)
        KIND_INSERT: begin
          unique case (tok_in.mode)
            MODE_SEARCH: begin
              if (key_q == tok_in.key) begin
                // duplicate key seen before a lower score
                tok_next.mode = MODE_DONE;
              end else if (score_q < tok_in.score) begin
                key_next         = tok_in.key;
                score_next       = tok_in.score;
                tok_next.key     = key_q;
                tok_next.score   = score_q;
                tok_next.mode    = MODE_SHIFT;
                tok_next.placed  = 1'b1;
                tok_next.pos     = PosW'(IDX);
              end
            end
            MODE_SHIFT: begin
              key_next       = tok_in.key;
              score_next     = tok_in.score;
              tok_next.key   = key_q;
              tok_next.score = score_q;
            end
            MODE_DONE: ;
            default: ;
          endcase
        end
        KIND_CLEAR: begin
          key_next   = '0;
          score_next = '0;
        end
        KIND_READ: begin
          if (int'(tok_in.idx) == IDX) begin
            tok_next.rkey   = key_q;
            tok_next.rscore = score_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_q   <= '0;
      score_q <= '0;
      tok_q   <= '0;
    end else if (adv) begin
      key_q   <= key_next;
      score_q <= score_next;
      tok_q   <= tok_next;
    end
  end

  assign tok_out   = tok_q;
  assign score_out = score_q;

endmodule

// ===== sv/top_k_ranked_list_unit.sv =====
// Top level of the top-k ranked list: row of rank cells plus result register.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  input   | in_valid / in_stall | kind, word_key, score, read_index
//  output  | out_valid/out_stall | inserted, position, count, entry_key, entry_score
//
// One operation is in flight at a time. A token enters cell 0 in the accept
// cycle and steps one cell per cycle down the row of ENTRIES cells while
// the row advances; the result is loaded as it leaves the last cell, and
// the next item can be taken in the cycle after that load.
// Reset (rst, synchronous) zeroes all entries, the fill count and the output valid.
// A held output freezes a token at the row's end until the result moves on;
// input is taken while a finished result still waits in the output register.
module top_k_ranked_list_unit import tkl_pkg::*; #(
  parameter int ENTRIES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        kind,
  input  logic [KeyW-1:0]   word_key,
  input  logic [ScoreW-1:0] score,
  input  logic [IdxW-1:0]   read_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              inserted,
  output logic [PosW-1:0]   position,
  output logic [CountW-1:0] count,
  output logic [KeyW-1:0]   entry_key,
  output logic [ScoreW-1:0] entry_score
);

  localparam int CW = $clog2(ENTRIES + 1);

  token_t            tok [0:ENTRIES];
  token_t            launch;
  logic [ScoreW-1:0] cell_score [0:ENTRIES-1];
  logic              busy;
  logic              adv;
  logic              accept;
  logic              exit_load;
  logic [CW-1:0]     filled;
  logic [CW-1:0]     filled_next;

  assign accept   = in_valid && !in_stall;
  assign in_stall = busy;

  // Row stalls only when the token has left the last cell and the
  // output register is still held.
  assign adv       = !(tok[ENTRIES].valid && out_valid && out_stall);
  assign exit_load = tok[ENTRIES].valid && adv;

  // Launch token. The admit threshold always equals the last rank's score,
  // so an insert that does not beat it is retired without a search.
  always_comb begin
    launch        = '0;
    launch.valid  = accept;
    launch.kind   = kind;
    launch.key    = word_key;
    launch.score  = score;
    launch.idx    = read_index;
    launch.mode   = MODE_SEARCH;
    if (kind == KIND_INSERT && score <= cell_score[ENTRIES-1]) begin
      launch.mode = MODE_DONE;
    end
  end

  assign tok[0] = launch;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    tkl_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1]),
      .score_out(cell_score[i])
    );
  end

  // Fill count after the retiring operation.
  always_comb begin
    filled_next = filled;
    if (tok[ENTRIES].kind == KIND_CLEAR) begin
      filled_next = '0;
    end else if (tok[ENTRIES].placed && filled < CW'(ENTRIES)) begin
      filled_next = filled + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      filled    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (exit_load) begin
        busy <= 1'b0;
      end
      if (exit_load) begin
        filled    <= filled_next;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (exit_load) begin
      inserted    <= tok[ENTRIES].placed;
      position    <= tok[ENTRIES].pos;
      count       <= CountW'(filled_next);
      entry_key   <= tok[ENTRIES].rkey;
      entry_score <= tok[ENTRIES].rscore;
    end
  end

endmodule

// ===== sv/tkl_checker.sv =====
// Port-level checks for the top-k ranked list, bound to the top level.
module tkl_checker import tkl_pkg::*; #(
  parameter int ENTRIES = 8
) (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic              inserted,
  input logic [PosW-1:0]   position,
  input logic [CountW-1:0] count,
  input logic [KeyW-1:0]   entry_key,
  input logic [ScoreW-1:0] entry_score
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(entry_key) && $stable(count))
    else $error("held result changed");

  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !inserted |-> position == '0)
    else $error("position set without insert");

  a_ins_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && inserted |-> entry_key == '0 && entry_score == '0 && count != '0)
    else $error("insert result carries read data or empty count");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ENTRIES > 15) || (int'(count) <= ENTRIES))
    else $error("count beyond row length");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind top_k_ranked_list_unit tkl_checker #(.ENTRIES(ENTRIES)) u_tkl_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .inserted   (inserted),
  .position   (position),
  .count      (count),
  .entry_key  (entry_key),
  .entry_score(entry_score)
);

// ===== bench/top_k_ranked_list_unit_checker.sv =====
// Transfer monitor, ranked list predictor and result comparison for the top-k list.
`timescale 1ns / 100ps

module ranked_list_checker import tkl_pkg::*; #(
  parameter int ENTRIES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        kind,
  input  logic [KeyW-1:0]   word_key,
  input  logic [ScoreW-1:0] score,
  input  logic [IdxW-1:0]   read_index,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              inserted,
  input  logic [PosW-1:0]   position,
  input  logic [CountW-1:0] count,
  input  logic [KeyW-1:0]   entry_key,
  input  logic [ScoreW-1:0] entry_score,
  output int                mismatches,
  output int                pending
);

  typedef struct packed {
    logic              inserted;
    logic [PosW-1:0]   position;
    logic [CountW-1:0] count;
    logic [KeyW-1:0]   key;
    logic [ScoreW-1:0] score;
  } outcome_t;

  logic [KeyW-1:0]   rank_key   [ENTRIES];
  logic [ScoreW-1:0] rank_score [ENTRIES];
  int unsigned       filled;
  logic [ScoreW-1:0] threshold;

  outcome_t predicted_results [$];
  outcome_t want;

  function automatic void clear_ranks();
    for (int i = 0; i < ENTRIES; i++) begin
      rank_key[i]   = '0;
      rank_score[i] = '0;
    end
    filled    = 0;
    threshold = '0;
  endfunction

  // Applies one operation to the local copy of the list and returns its result.
  function automatic outcome_t rank_update(logic [1:0] op, logic [KeyW-1:0] key,
                                           logic [ScoreW-1:0] sc, logic [IdxW-1:0] idx);
    outcome_t r;
    bit       searching;
    bit       dup;
    int       slot;
    r = '0;
    case (op)
      KIND_INSERT: begin
        if (sc > threshold) begin
          searching = 1'b1;
          dup       = 1'b0;
          slot      = ENTRIES;
          // empty slots hold key 0 and still take part in the key compare
          for (int i = 0; i < ENTRIES; i++) begin
            if (searching) begin
              if (rank_key[i] == key) begin
                searching = 1'b0;
                dup       = 1'b1;
              end else if (rank_score[i] < sc) begin
                searching = 1'b0;
                slot      = i;
              end
            end
          end
          if (!dup && slot < ENTRIES) begin
            if (filled < ENTRIES) filled++;
            for (int j = ENTRIES - 1; j > slot; j--) begin
              rank_key[j]   = rank_key[j-1];
              rank_score[j] = rank_score[j-1];
            end
            rank_key[slot]   = key;
            rank_score[slot] = sc;
            threshold        = rank_score[ENTRIES-1];
            r.inserted       = 1'b1;
            r.position       = slot[PosW-1:0];
          end
        end
      end
      KIND_CLEAR: clear_ranks();
      KIND_READ: begin
        if (idx < ENTRIES) begin
          r.key   = rank_key[idx];
          r.score = rank_score[idx];
        end
      end
      default: ;
    endcase
    r.count = filled[CountW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [KeyW-1:0] got, logic [KeyW-1:0] exp_val);
    $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, exp_val);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_ranks();
      predicted_results.delete();
      mismatches = 0;
      pending <= 0;
    end else begin
      // output side first so a result never meets the expectation pushed this cycle
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("unexpected transfer", entry_key, '0);
        end else begin
          want = predicted_results.pop_front();
          if (inserted !== want.inserted) report_mismatch("inserted", inserted, want.inserted);
          if (position !== want.position) report_mismatch("position", position, want.position);
          if (count !== want.count) report_mismatch("count", count, want.count);
          if (entry_key !== want.key) report_mismatch("entry_key", entry_key, want.key);
          if (entry_score !== want.score)
            report_mismatch("entry_score", entry_score, want.score);
        end
      end
      if (in_valid && !in_stall)
        predicted_results.push_back(rank_update(kind, word_key, score, read_index));
      pending <= predicted_results.size();
    end
  end

endmodule

// ===== bench/top_k_ranked_list_unit_test.sv =====
// Top of the top-k ranked list regression: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module top_k_ranked_list_unit_test import tkl_pkg::*;;

  localparam int ENTRIES = 8;
  // kind code that the block treats as a no-op
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 267;
  // cycles with no transfer on either channel before the run is declared hung;
  // one item costs at most a random send gap, the walk down the row and
  // a receiver stall run, so this is far beyond any correct run
  localparam int HANG_LIMIT = 4000;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        kind;
  logic [KeyW-1:0]   word_key;
  logic [ScoreW-1:0] score;
  logic [IdxW-1:0]   read_index;
  logic              out_valid;
  logic              out_stall;
  logic              inserted;
  logic [PosW-1:0]   position;
  logic [CountW-1:0] count;
  logic [KeyW-1:0]   entry_key;
  logic [ScoreW-1:0] entry_score;

  int mismatches;
  int pending;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;

  top_k_ranked_list_unit #(.ENTRIES(ENTRIES)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .word_key(word_key), .score(score), .read_index(read_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .inserted(inserted), .position(position), .count(count),
    .entry_key(entry_key), .entry_score(entry_score)
  );

  ranked_list_checker #(.ENTRIES(ENTRIES)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .word_key(word_key), .score(score), .read_index(read_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .inserted(inserted), .position(position), .count(count),
    .entry_key(entry_key), .entry_score(entry_score),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: stall at random; the rate is changed per phase with an NBA so
  // this block always sees a settled value.
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: counts cycles in which neither channel moves a transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("top_k_ranked_list_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one operation and hold it until the block takes the transfer.
  // A random gap of idle cycles may come first, long enough to land on any
  // step of the row's walk.
  task automatic send_op(input logic [1:0] op, input logic [KeyW-1:0] key,
                         input logic [ScoreW-1:0] sc, input logic [IdxW-1:0] idx);
    int gap;
    gap = 0;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
      gap = $urandom_range(1, ENTRIES + 2);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    kind       <= op;
    word_key   <= key;
    score      <= sc;
    read_index <= idx;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold the sender back until every expected result has been returned.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int               n;
    int               phase;
    int               pick;
    logic [1:0]       op;
    logic [KeyW-1:0]  key;
    logic [ScoreW-1:0] sc;

    rst           = 1'b1;
    in_valid      = 1'b0;
    kind          = KIND_INSERT;
    word_key      = '0;
    score         = '0;
    read_index    = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 35;
    recv_idle_pct <= 45;

    // ---- directed part ----
    send_op(KIND_READ, '0, '0, 3'd0);                 // read of an empty list
    send_op(KIND_INSERT, '0, 32'd5, '0);              // key 0 meets an empty slot: duplicate
    send_op(KIND_INSERT, 64'h1234, '0, '0);           // zero score never admitted
    send_op(KIND_INSERT, '1, '1, '0);                 // extreme key and score, goes to the top
    send_op(KIND_INSERT, '1, 32'd10, '0);             // same key again: duplicate
    // fill the list past its depth with rising scores, each lands near the top
    for (n = 0; n < ENTRIES; n++)
      send_op(KIND_INSERT, 64'hA5A5_0000_0000_0000 | 64'(n), 32'((n + 1) << 8), '0);
    send_op(KIND_INSERT, 64'h77, 32'h200, '0);        // equal to the threshold: dropped
    send_op(KIND_INSERT, 64'h78, 32'h201, '0);        // just above: replaces the last rank
    send_op(KIND_INSERT, '0, 32'h7FFF_FFFF, '0);      // key 0 once no empty slot is left
    send_op(KIND_UNUSED, '1, '1, '1);                 // unused kind changes nothing
    for (n = 0; n < ENTRIES; n++)
      send_op(KIND_READ, '1, '1, 3'(n));
    send_op(KIND_CLEAR, '1, '1, '1);
    send_op(KIND_READ, '0, '0, 3'd7);

    // ---- random part, three phases with different idle rates ----
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 35; recv_idle_pct <= 45; end
        1: begin send_idle_pct = 45; recv_idle_pct <= 35; end
        default: begin send_idle_pct = 0; recv_idle_pct <= 0; end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == 100) drain_results();
        pick = $urandom_range(99);
        if (pick < 72) op = KIND_INSERT;
        else if (pick < 92) op = KIND_READ;
        else if (pick < 97) op = KIND_UNUSED;
        else op = KIND_CLEAR;
        // small key pool (with 0) gives duplicates; wide keys toggle every bit
        if ($urandom_range(99) < 60) key = 64'($urandom_range(0, 11));
        else key = {$urandom, $urandom};
        // small scores give ties and threshold hits; wide scores push the threshold up
        if ($urandom_range(99) < 55) sc = 32'($urandom_range(0, 24));
        else sc = $urandom;
        send_op(op, key, sc, 3'($urandom_range(0, 7)));
      end
    end

    // ---- wind down ----
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (ENTRIES + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("top_k_ranked_list_unit regression: pass");
    end else begin
      $display("top_k_ranked_list_unit regression: fail");
    end
    $finish;
  end

endmodule
